[src/skvl_pkg.sv]
// ----------------------------------------------------------------------------
// skvl_pkg: shared types and codes for the sorted key/value list
// Request codes, result status codes and the control bundle that the
// sequencer broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package skvl_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 4;
  localparam int unsigned CntW  = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast control from the sequencer to the cell row
  typedef struct packed {
    logic cmp;        // capture compare flags against the incoming key
    logic ins;        // apply an insert (table not full)
    logic del;        // apply a delete (a match exists)
    logic clr;        // empty the table
    logic pick_ins;   // report the insert slot
    logic pick_match; // report the first matching slot
  } cell_ctl_t;

endpackage

[src/skvl_cell.sv]
// ----------------------------------------------------------------------------
// skvl_cell: one slot of the sorted list
// Holds one key/value pair and its valid bit, compares against the request
// key, and shifts toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module skvl_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  skvl_pkg::cell_ctl_t             ctl,
  input  logic signed [skvl_pkg::KeyW-1:0] cmp_key,
  input  logic signed [skvl_pkg::KeyW-1:0] new_key,
  input  logic [skvl_pkg::ValW-1:0]       new_val,
  // left neighbor (lower index)
  input  logic                            prev_le,
  input  logic                            prev_eq,
  input  logic signed [skvl_pkg::KeyW-1:0] prev_key,
  input  logic [skvl_pkg::ValW-1:0]       prev_val,
  input  logic                            prev_valid,
  // right neighbor (higher index)
  input  logic signed [skvl_pkg::KeyW-1:0] next_key,
  input  logic [skvl_pkg::ValW-1:0]       next_val,
  input  logic                            next_valid,
  // own state toward neighbors and reduction
  output logic                            le,
  output logic                            eq,
  output logic signed [skvl_pkg::KeyW-1:0] key,
  output logic [skvl_pkg::ValW-1:0]       val,
  output logic                            valid,
  output logic                            sel,
  output logic [skvl_pkg::ValW-1:0]       sel_val
);
  import skvl_pkg::*;

  logic                   valid_r, valid_nxt;
  logic signed [KeyW-1:0] key_r, key_nxt;
  logic [ValW-1:0]        val_r, val_nxt;
  logic                   le_r, eq_r;
  logic                   at_slot, after_slot, first_hit, below_hit;

  // Sorted order makes these decisions local to the cell
  assign at_slot    = prev_le && !le_r;
  assign after_slot = !prev_le;
  assign first_hit  = eq_r && !prev_eq;
  assign below_hit  = le_r && !eq_r;

  assign sel     = (ctl.pick_ins && at_slot) || (ctl.pick_match && first_hit);
  assign sel_val = sel ? val_r : '0;

  // Compare flags, captured when the request is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp) begin
      le_r <= valid_r && (key_r <= cmp_key);
      eq_r <= valid_r && (key_r == cmp_key);
    end
  end

  // Slot update: load, shift up, shift down or clear
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    priority if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins && at_slot) begin
      valid_nxt = 1'b1;
      key_nxt   = new_key;
      val_nxt   = new_val;
    end else if (ctl.ins && after_slot) begin
      valid_nxt = prev_valid;
      key_nxt   = prev_key;
      val_nxt   = prev_val;
    end else if (ctl.del && !below_hit) begin
      valid_nxt = next_valid;
      key_nxt   = next_key;
      val_nxt   = next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign le    = le_r;
  assign eq    = eq_r;
  assign key   = key_r;
  assign val   = val_r;
  assign valid = valid_r;

endmodule

[src/sorted_key_value_list_unit.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_list_unit: sorted key/value table in a row of cells
// Keeps up to CAPACITY entries in ascending signed key order and carries
// out insert, search, delete and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with in_operation, in_key and in_value while busy is low;
//   the request is taken at that clock edge. busy then stays high for one
//   cycle while the cells apply the request.
//   Every cell compares its key with the request key in the cycle the
//   request is taken; in the next cycle each cell decides from its own and
//   its neighbor's flags whether to load, shift up, shift down or clear.
//   One result follows each request: out_valid is registered from the apply
//   state and is held for one cycle with out_status, out_position,
//   out_found_value and out_entry_count. A new request can be taken only
//   once busy is low again, independent of CAPACITY.
//   The receiver cannot stall: a result is taken in the cycle it is shown.
//   Reset (rst_n low, synchronous) empties the table and drops any request
//   in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_key_value_list_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       in_operation,
  input  logic signed [skvl_pkg::KeyW-1:0] in_key,
  input  logic [skvl_pkg::ValW-1:0]        in_value,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [skvl_pkg::PosW-1:0]        out_position,
  output logic [skvl_pkg::ValW-1:0]        out_found_value,
  output logic [skvl_pkg::CntW-1:0]        out_entry_count
);
  import skvl_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r;
  logic signed [KeyW-1:0] key_r;
  logic [ValW-1:0]        val_r;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   accept;
  logic                   full, empty, hit;
  cell_ctl_t              ctl;

  logic                   out_valid_r;
  status_t                status_nxt, status_r;
  logic [PosW-1:0]        pos_nxt, pos_r;
  logic [ValW-1:0]        fval_nxt, fval_r;
  logic [CntW-1:0]        cnt_out_nxt, cnt_out_r;

  // Cell row wiring
  logic                   c_le    [CAPACITY];
  logic                   c_eq    [CAPACITY];
  logic signed [KeyW-1:0] c_key   [CAPACITY];
  logic [ValW-1:0]        c_val   [CAPACITY];
  logic                   c_valid [CAPACITY];
  logic [CAPACITY-1:0]    c_sel;
  logic [ValW-1:0]        c_selv  [CAPACITY];

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Sequencer
  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_APPLY : S_IDLE;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request hold
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_operation);
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);

  // Any match in the table
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      hit = hit | c_eq[i];
    end
  end

  // Broadcast control
  always_comb begin
    logic apply;
    apply          = (state_r == S_APPLY);
    ctl.cmp        = accept;
    ctl.ins        = apply && (op_r == OP_INSERT) && !full;
    ctl.del        = apply && (op_r == OP_DELETE) && hit;
    ctl.clr        = apply && (op_r == OP_CLEAR);
    ctl.pick_ins   = apply && (op_r == OP_INSERT) && !full;
    ctl.pick_match = apply && ((op_r == OP_SEARCH) || (op_r == OP_DELETE));
  end

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   p_le, p_eq, p_valid, n_valid;
    logic signed [KeyW-1:0] p_key, n_key;
    logic [ValW-1:0]        p_val, n_val;

    if (i == 0) begin : g_head
      assign p_le    = 1'b1;
      assign p_eq    = 1'b0;
      assign p_key   = '0;
      assign p_val   = '0;
      assign p_valid = 1'b0;
    end else begin : g_body
      assign p_le    = c_le[i-1];
      assign p_eq    = c_eq[i-1];
      assign p_key   = c_key[i-1];
      assign p_val   = c_val[i-1];
      assign p_valid = c_valid[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_key   = '0;
      assign n_val   = '0;
      assign n_valid = 1'b0;
    end else begin : g_mid
      assign n_key   = c_key[i+1];
      assign n_val   = c_val[i+1];
      assign n_valid = c_valid[i+1];
    end

    skvl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .cmp_key    (in_key),
      .new_key    (key_r),
      .new_val    (val_r),
      .prev_le    (p_le),
      .prev_eq    (p_eq),
      .prev_key   (p_key),
      .prev_val   (p_val),
      .prev_valid (p_valid),
      .next_key   (n_key),
      .next_val   (n_val),
      .next_valid (n_valid),
      .le         (c_le[i]),
      .eq         (c_eq[i]),
      .key        (c_key[i]),
      .val        (c_val[i]),
      .valid      (c_valid[i]),
      .sel        (c_sel[i]),
      .sel_val    (c_selv[i])
    );
  end

  // Position of the selected slot, low bits only
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      pos_nxt = pos_nxt | ({PosW{c_sel[i]}} & PosW'(i));
    end
  end

  // Value of the selected slot, search only
  always_comb begin
    fval_nxt = '0;
    for (int i = 0; i < int'(CAPACITY); i++) begin
      fval_nxt = fval_nxt | c_selv[i];
    end
    if (op_r != OP_SEARCH) begin
      fval_nxt = '0;
    end
  end

  // Status and entry count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    unique case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
        end
      end
      OP_SEARCH: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_MISS;
        end
      end
      OP_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_MISS;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      OP_CLEAR: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end
        count_nxt = '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // Entry count reported in its low bits
  if (CW >= CntW) begin : g_cnt_trunc
    assign cnt_out_nxt = count_nxt[CntW-1:0];
  end else begin : g_cnt_ext
    assign cnt_out_nxt = {{(CntW-CW){1'b0}}, count_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_APPLY);
      if (state_r == S_APPLY) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == S_APPLY) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      fval_r    <= fval_nxt;
      cnt_out_r <= cnt_out_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = pos_r;
  assign out_found_value = fval_r;
  assign out_entry_count = cnt_out_r;

endmodule
